FILE: rtl/core/tpsc_pkg.sv
// ----------------------------------------------------------------------------
// tpsc_pkg
// Shared types, constants and the divider step for the two-point
// sensor calibration pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsc_pkg;

    localparam int NUM_CH  = 2;
    localparam int CH_HUM  = 0;
    localparam int CH_TEMP = 1;

    localparam int RAW_W   = 16;
    localparam int DIFF_W  = RAW_W + 1;
    localparam int PT_W    = 10;
    localparam int DY_W    = PT_W + 1;
    localparam int PROD_W  = DY_W + DIFF_W;
    localparam int NUM_W   = 32;
    localparam int DVS_W   = 16;
    localparam int OFS_W   = 13;
    localparam int QS_W    = NUM_W + 1;
    localparam int SUM_W   = QS_W + 1;
    localparam int OUT_W   = 16;

    localparam int HUM_SHIFT  = 6;
    localparam int TEMP_SHIFT = 3;

    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = NUM_W / DIV_BITS_PER_STAGE;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 34'sd32767;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -34'sd32768;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_SAT       = 2'd1,
        ERR_ZERO_SPAN = 2'd2
    } cal_err_t;

    typedef enum logic [2:0] {
        REG_HUM_LOW_RH   = 3'd0,
        REG_HUM_HIGH_RH  = 3'd1,
        REG_HUM_LOW_RAW  = 3'd2,
        REG_HUM_HIGH_RAW = 3'd3,
        REG_TMP_LOW_X8   = 3'd4,
        REG_TMP_HIGH_X8  = 3'd5,
        REG_TMP_LOW_RAW  = 3'd6,
        REG_TMP_HIGH_RAW = 3'd7
    } cal_reg_t;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } div_state_t;

    function automatic div_state_t div_step(input div_state_t st,
                                            input logic [DVS_W-1:0] dvs);
        div_state_t       res;
        logic [DVS_W:0]   trial;
        res = st;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            trial = {res.rem, res.quo[NUM_W-1]};
            if (trial >= {1'b0, dvs})
            begin
                res.rem = DVS_W'(trial - {1'b0, dvs});
                res.quo = {res.quo[NUM_W-2:0], 1'b1};
            end
            else
            begin
                res.rem = trial[DVS_W-1:0];
                res.quo = {res.quo[NUM_W-2:0], 1'b0};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/two_point_sensor_calibration.sv
// ----------------------------------------------------------------------------
// two_point_sensor_calibration
// Maps raw humidity and temperature samples to 1/64-unit physical values
// by two-point linear interpolation, with saturation and zero-span flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one raw_humidity/raw_temperature
//   beat; output channel (out_valid/out_stall) carries one result beat with
//   both calibrated values and their error codes.
//   Calibration points are to be written over the APB port while the block
//   is idle; the block itself does not enforce this. An accepted input beat
//   passes through span and offset subtract, multiply, magnitude, 8 divider
//   stages of 4 quotient bits, sign restore, then offset add and saturation
//   into the output register. Throughput is one beat per cycle unless stalled;
//   the 32-bit restoring divider is fully pipelined, one instance per channel.
//   When out_stall is high with a result waiting, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and loads the register defaults (raw high
//   points 1, all others 0); no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module two_point_sensor_calibration
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [tpsc_pkg::RAW_W-1:0]  raw_humidity,
    input  wire logic signed [tpsc_pkg::RAW_W-1:0]  raw_temperature,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [tpsc_pkg::OUT_W-1:0]       humidity_q6,
    output logic signed [tpsc_pkg::OUT_W-1:0]       temperature_q6,
    output logic [1:0]                              humidity_error,
    output logic [1:0]                              temperature_error,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tpsc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [tpsc_pkg::DATA_W-1:0]        pwdata,
    output logic [tpsc_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready
);

    localparam int NCH = tpsc_pkg::NUM_CH;
    localparam int NDS = tpsc_pkg::DIV_STAGES;

    // Configuration registers
    logic [6:0]                         hum_lo_rh_reg;
    logic [6:0]                         hum_hi_rh_reg;
    logic [tpsc_pkg::RAW_W-1:0]         hum_lo_raw_reg;
    logic [tpsc_pkg::RAW_W-1:0]         hum_hi_raw_reg;
    logic [tpsc_pkg::PT_W-1:0]          tmp_lo_x8_reg;
    logic [tpsc_pkg::PT_W-1:0]          tmp_hi_x8_reg;
    logic [tpsc_pkg::RAW_W-1:0]         tmp_lo_raw_reg;
    logic [tpsc_pkg::RAW_W-1:0]         tmp_hi_raw_reg;

    tpsc_pkg::cal_reg_t                 reg_sel;
    logic                               cfg_wr;

    // Per-channel views of the configuration
    logic [tpsc_pkg::PT_W-1:0]          y0 [NCH];
    logic [tpsc_pkg::PT_W-1:0]          y1 [NCH];
    logic [tpsc_pkg::RAW_W-1:0]         x0 [NCH];
    logic [tpsc_pkg::RAW_W-1:0]         x1 [NCH];
    logic [tpsc_pkg::OFS_W-1:0]         ofs [NCH];
    logic [tpsc_pkg::RAW_W-1:0]         raw_in [NCH];

    logic                               adv;

    // Stage 1: differences
    logic                               s1_valid_reg;
    logic signed [tpsc_pkg::DIFF_W-1:0] s1_dx_reg  [NCH];
    logic signed [tpsc_pkg::DIFF_W-1:0] s1_den_reg [NCH];
    logic signed [tpsc_pkg::DY_W-1:0]   s1_dy_reg  [NCH];

    // Stage 2: scaled numerator
    logic                               s2_valid_reg;
    logic signed [tpsc_pkg::PROD_W-1:0] s2_prod    [NCH];
    logic signed [tpsc_pkg::NUM_W-1:0]  s2_num_reg [NCH];
    logic signed [tpsc_pkg::DIFF_W-1:0] s2_den_reg [NCH];

    // Divider stages; index 0 holds the magnitudes entering the divider
    logic                               dv_valid_reg [NDS+1];
    tpsc_pkg::div_state_t               dv_st_reg    [NDS+1][NCH];
    logic [tpsc_pkg::DVS_W-1:0]         dv_dvs_reg   [NDS+1][NCH];
    logic                               dv_neg_reg   [NDS+1][NCH];
    logic                               dv_zero_reg  [NDS+1][NCH];

    // Sign restore stage
    logic                               sg_valid_reg;
    logic signed [tpsc_pkg::QS_W-1:0]   sg_q_reg    [NCH];
    logic                               sg_zero_reg [NCH];

    // Output stage
    logic signed [tpsc_pkg::SUM_W-1:0]  fin_sum [NCH];
    logic signed [tpsc_pkg::OUT_W-1:0]  fin_val [NCH];
    tpsc_pkg::cal_err_t                 fin_err [NCH];
    logic                               out_valid_reg;
    logic signed [tpsc_pkg::OUT_W-1:0]  out_val_reg [NCH];
    tpsc_pkg::cal_err_t                 out_err_reg [NCH];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign reg_sel = tpsc_pkg::cal_reg_t'(paddr[tpsc_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hum_lo_rh_reg  <= '0;
            hum_hi_rh_reg  <= '0;
            hum_lo_raw_reg <= '0;
            hum_hi_raw_reg <= 16'd1;
            tmp_lo_x8_reg  <= '0;
            tmp_hi_x8_reg  <= '0;
            tmp_lo_raw_reg <= '0;
            tmp_hi_raw_reg <= 16'd1;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                tpsc_pkg::REG_HUM_LOW_RH:   hum_lo_rh_reg  <= pwdata[6:0];
                tpsc_pkg::REG_HUM_HIGH_RH:  hum_hi_rh_reg  <= pwdata[6:0];
                tpsc_pkg::REG_HUM_LOW_RAW:  hum_lo_raw_reg <= pwdata[15:0];
                tpsc_pkg::REG_HUM_HIGH_RAW: hum_hi_raw_reg <= pwdata[15:0];
                tpsc_pkg::REG_TMP_LOW_X8:   tmp_lo_x8_reg  <= pwdata[9:0];
                tpsc_pkg::REG_TMP_HIGH_X8:  tmp_hi_x8_reg  <= pwdata[9:0];
                tpsc_pkg::REG_TMP_LOW_RAW:  tmp_lo_raw_reg <= pwdata[15:0];
                tpsc_pkg::REG_TMP_HIGH_RAW: tmp_hi_raw_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            tpsc_pkg::REG_HUM_LOW_RH:   prdata = {25'd0, hum_lo_rh_reg};
            tpsc_pkg::REG_HUM_HIGH_RH:  prdata = {25'd0, hum_hi_rh_reg};
            tpsc_pkg::REG_HUM_LOW_RAW:  prdata = {16'd0, hum_lo_raw_reg};
            tpsc_pkg::REG_HUM_HIGH_RAW: prdata = {16'd0, hum_hi_raw_reg};
            tpsc_pkg::REG_TMP_LOW_X8:   prdata = {22'd0, tmp_lo_x8_reg};
            tpsc_pkg::REG_TMP_HIGH_X8:  prdata = {22'd0, tmp_hi_x8_reg};
            tpsc_pkg::REG_TMP_LOW_RAW:  prdata = {16'd0, tmp_lo_raw_reg};
            tpsc_pkg::REG_TMP_HIGH_RAW: prdata = {16'd0, tmp_hi_raw_reg};
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        y0[tpsc_pkg::CH_HUM]      = {3'd0, hum_lo_rh_reg};
        y1[tpsc_pkg::CH_HUM]      = {3'd0, hum_hi_rh_reg};
        x0[tpsc_pkg::CH_HUM]      = hum_lo_raw_reg;
        x1[tpsc_pkg::CH_HUM]      = hum_hi_raw_reg;
        ofs[tpsc_pkg::CH_HUM]     = {hum_lo_rh_reg, 6'd0};
        raw_in[tpsc_pkg::CH_HUM]  = raw_humidity;
        y0[tpsc_pkg::CH_TEMP]     = tmp_lo_x8_reg;
        y1[tpsc_pkg::CH_TEMP]     = tmp_hi_x8_reg;
        x0[tpsc_pkg::CH_TEMP]     = tmp_lo_raw_reg;
        x1[tpsc_pkg::CH_TEMP]     = tmp_hi_raw_reg;
        ofs[tpsc_pkg::CH_TEMP]    = {tmp_lo_x8_reg, 3'd0};
        raw_in[tpsc_pkg::CH_TEMP] = raw_temperature;
    end

    // ------------------------------------------------------------------
    // Pipeline control: advance unless a result waits on a stalled sink
    // ------------------------------------------------------------------
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            sg_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= NDS; s++)
            begin
                dv_valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            dv_valid_reg[0] <= s2_valid_reg;
            for (int s = 1; s <= NDS; s++)
            begin
                dv_valid_reg[s] <= dv_valid_reg[s-1];
            end
            sg_valid_reg    <= dv_valid_reg[NDS];
            out_valid_reg   <= sg_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            s2_prod[c] = s1_dy_reg[c] * s1_dx_reg[c];
            fin_sum[c] = tpsc_pkg::SUM_W'(sg_q_reg[c])
                       + $signed({{(tpsc_pkg::SUM_W-tpsc_pkg::OFS_W){1'b0}}, ofs[c]});
            if (sg_zero_reg[c])
            begin
                fin_val[c] = '0;
                fin_err[c] = tpsc_pkg::ERR_ZERO_SPAN;
            end
            else if (fin_sum[c] > tpsc_pkg::SAT_MAX)
            begin
                fin_val[c] = 16'sh7FFF;
                fin_err[c] = tpsc_pkg::ERR_SAT;
            end
            else if (fin_sum[c] < tpsc_pkg::SAT_MIN)
            begin
                fin_val[c] = -16'sh8000;
                fin_err[c] = tpsc_pkg::ERR_SAT;
            end
            else
            begin
                fin_val[c] = fin_sum[c][tpsc_pkg::OUT_W-1:0];
                fin_err[c] = tpsc_pkg::ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                s1_dx_reg[c]  <= $signed({raw_in[c][tpsc_pkg::RAW_W-1], raw_in[c]})
                               - $signed({x0[c][tpsc_pkg::RAW_W-1], x0[c]});
                s1_den_reg[c] <= $signed({x1[c][tpsc_pkg::RAW_W-1], x1[c]})
                               - $signed({x0[c][tpsc_pkg::RAW_W-1], x0[c]});
                s1_dy_reg[c]  <= $signed({1'b0, y1[c]}) - $signed({1'b0, y0[c]});

                if (c == tpsc_pkg::CH_HUM)
                begin
                    s2_num_reg[c] <= tpsc_pkg::NUM_W'(s2_prod[c]) <<< tpsc_pkg::HUM_SHIFT;
                end
                else
                begin
                    s2_num_reg[c] <= tpsc_pkg::NUM_W'(s2_prod[c]) <<< tpsc_pkg::TEMP_SHIFT;
                end
                s2_den_reg[c] <= s1_den_reg[c];

                dv_st_reg[0][c].rem <= '0;
                dv_st_reg[0][c].quo <= s2_num_reg[c][tpsc_pkg::NUM_W-1]
                                     ? tpsc_pkg::NUM_W'(-s2_num_reg[c])
                                     : tpsc_pkg::NUM_W'(s2_num_reg[c]);
                dv_dvs_reg[0][c]    <= s2_den_reg[c][tpsc_pkg::DIFF_W-1]
                                     ? tpsc_pkg::DVS_W'(-s2_den_reg[c])
                                     : tpsc_pkg::DVS_W'(s2_den_reg[c]);
                dv_neg_reg[0][c]    <= s2_num_reg[c][tpsc_pkg::NUM_W-1]
                                     ^ s2_den_reg[c][tpsc_pkg::DIFF_W-1];
                dv_zero_reg[0][c]   <= (s2_den_reg[c] == '0);

                for (int s = 1; s <= NDS; s++)
                begin
                    dv_st_reg[s][c]   <= tpsc_pkg::div_step(dv_st_reg[s-1][c],
                                                            dv_dvs_reg[s-1][c]);
                    dv_dvs_reg[s][c]  <= dv_dvs_reg[s-1][c];
                    dv_neg_reg[s][c]  <= dv_neg_reg[s-1][c];
                    dv_zero_reg[s][c] <= dv_zero_reg[s-1][c];
                end

                sg_q_reg[c]    <= dv_neg_reg[NDS][c]
                                ? -$signed({1'b0, dv_st_reg[NDS][c].quo})
                                : $signed({1'b0, dv_st_reg[NDS][c].quo});
                sg_zero_reg[c] <= dv_zero_reg[NDS][c];

                out_val_reg[c] <= fin_val[c];
                out_err_reg[c] <= fin_err[c];
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign humidity_q6       = out_val_reg[tpsc_pkg::CH_HUM];
    assign temperature_q6    = out_val_reg[tpsc_pkg::CH_TEMP];
    assign humidity_error    = out_err_reg[tpsc_pkg::CH_HUM];
    assign temperature_error = out_err_reg[tpsc_pkg::CH_TEMP];

endmodule

`default_nettype wire
